// ===== rtl/ffsc_pkg.sv =====
`default_nettype none

package ffsc_pkg;

  localparam int unsigned FrameBytesDef = 63;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW = 6;
  localparam logic [ByteW-1:0] HdrByte = 8'hFF;
  localparam int unsigned HdrPos1 = 1;
  localparam int unsigned FirstPayloadPos = 2;

  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhOne   = 2'd1,
    PhFrame = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [PosW-1:0]  position;
    logic             frame_end;
    logic             frame_ok;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ffsc_tracker.sv =====
`default_nettype none

module ffsc_tracker #(
  parameter int unsigned FRAME_BYTES = ffsc_pkg::FrameBytesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [ffsc_pkg::ByteW-1:0] rx_byte_i,
  output logic                            res_valid_o,
  output ffsc_pkg::res_t                  res_o
);

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BYTES - 1);

  ffsc_pkg::phase_e            phase_q, phase_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [ffsc_pkg::ByteW-1:0]  sum_q, sum_d;
  logic [IdxW+ffsc_pkg::PosW-1:0] idx_ext;
  logic                        is_hdr;
  logic                        is_last;

  assign is_hdr  = (rx_byte_i == ffsc_pkg::HdrByte);
  assign is_last = (idx_q == LastIdx);
  assign idx_ext = {{ffsc_pkg::PosW{1'b0}}, idx_q};

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    if (accept_i) begin
      case (phase_q)
        ffsc_pkg::PhFrame: begin
          if (is_last) begin
            phase_d = ffsc_pkg::PhHunt;
            idx_d   = '0;
            sum_d   = '0;
          end else begin
            sum_d = sum_q + rx_byte_i;
            idx_d = idx_q + IdxW'(1);
          end
        end
        ffsc_pkg::PhOne: begin
          if (is_hdr) begin
            phase_d = ffsc_pkg::PhFrame;
            idx_d   = IdxW'(ffsc_pkg::FirstPayloadPos);
            sum_d   = '0;
          end else begin
            phase_d = ffsc_pkg::PhHunt;
            idx_d   = '0;
          end
        end
        default: begin
          if (is_hdr) begin
            phase_d = ffsc_pkg::PhOne;
            idx_d   = IdxW'(ffsc_pkg::HdrPos1);
          end else begin
            phase_d = ffsc_pkg::PhHunt;
            idx_d   = '0;
          end
          sum_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    res_valid_o     = 1'b0;
    res_o.data_byte = rx_byte_i;
    res_o.position  = idx_ext[ffsc_pkg::PosW-1:0];
    res_o.frame_end = 1'b0;
    res_o.frame_ok  = 1'b0;
    case (phase_q)
      ffsc_pkg::PhFrame: begin
        res_valid_o     = accept_i;
        res_o.frame_end = is_last;
        res_o.frame_ok  = is_last && (rx_byte_i == ~sum_q);
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ffsc_pkg::PhHunt;
      idx_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffsc_out_reg.sv =====
`default_nettype none

module ffsc_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_valid_i,
  input  wire ffsc_pkg::res_t res_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ffsc_pkg::res_t      res_o
);

  logic           valid_q, valid_d;
  ffsc_pkg::res_t res_q;

  assign take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/fixed_frame_sync_checksum_rx.sv =====
// A result item is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single output register stalls input only while
// it holds an item that is not taken.
// Reset (rst_ni low, asynchronous): header hunting, index and sum cleared, output empty.
`default_nettype none

module fixed_frame_sync_checksum_rx #(
  parameter int unsigned FRAME_BYTES = ffsc_pkg::FrameBytesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rx_valid_i,
  output logic                            rx_ready_o,
  input  wire logic [ffsc_pkg::ByteW-1:0] rx_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [ffsc_pkg::ByteW-1:0]      data_byte_o,
  output logic [ffsc_pkg::PosW-1:0]       position_o,
  output logic                            frame_end_o,
  output logic                            frame_ok_o
);

  logic           take;
  logic           accept;
  logic           res_valid;
  ffsc_pkg::res_t res;
  ffsc_pkg::res_t res_out;

  assign rx_ready_o = take;
  assign accept     = rx_valid_i && take;

  ffsc_tracker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ffsc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .take_o     (take),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign data_byte_o = res_out.data_byte;
  assign position_o  = res_out.position;
  assign frame_end_o = res_out.frame_end;
  assign frame_ok_o  = res_out.frame_ok;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ffsc_pkg::*;

  localparam int unsigned FrameLen = FrameBytesDef;
  localparam int unsigned PayloadLen = FrameLen - 3;
  localparam int unsigned RandomBytes = 1750;
  localparam int unsigned CycleLimit = 1000000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             rx_valid_i = 1'b0;
  logic             rx_ready_o;
  logic [ByteW-1:0] rx_byte_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ByteW-1:0] data_byte_o;
  logic [PosW-1:0]  position_o;
  logic             frame_end_o;
  logic             frame_ok_o;

  logic [ByteW-1:0] rx_stream[$];
  res_t             frame_results[$];

  phase_e           sync_ph = PhHunt;
  int unsigned      next_pos = 0;
  logic [ByteW-1:0] payload_sum = '0;

  int unsigned      fail_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      tx_gap = 0;
  int unsigned      rx_stall = 0;

  fixed_frame_sync_checksum_rx dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_byte_o(data_byte_o),
    .position_o (position_o),
    .frame_end_o(frame_end_o),
    .frame_ok_o (frame_ok_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Fill modes: 0 random, 1 alternating 0xFF/0x00, 2 mostly 0xFF, 3 all zero.
  task automatic add_frame(bit good, int unsigned fill);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    sum = '0;
    rx_stream.push_back(HdrByte);
    rx_stream.push_back(HdrByte);
    for (int unsigned k = 0; k < PayloadLen; k++) begin
      case (fill)
        1: b = (k % 2 == 0) ? 8'hFF : 8'h00;
        2: b = ($urandom_range(3) != 0) ? 8'hFF : 8'($urandom_range(255));
        3: b = 8'h00;
        default: b = 8'($urandom_range(255));
      endcase
      sum = sum + b;
      rx_stream.push_back(b);
    end
    if (good) begin
      rx_stream.push_back(~sum);
    end else begin
      rx_stream.push_back(~sum ^ 8'($urandom_range(255, 1)));
    end
  endtask

  task automatic predict_rx(input logic [ByteW-1:0] b);
    res_t r;
    case (sync_ph)
      PhFrame: begin
        r.data_byte = b;
        r.position = next_pos[PosW-1:0];
        if (next_pos >= FrameLen - 1) begin
          r.frame_end = 1'b1;
          r.frame_ok = (b == 8'(~payload_sum));
          sync_ph = PhHunt;
          next_pos = 0;
          payload_sum = '0;
        end else begin
          r.frame_end = 1'b0;
          r.frame_ok = 1'b0;
          payload_sum = payload_sum + b;
          next_pos = next_pos + 1;
        end
        frame_results.push_back(r);
      end
      PhOne: begin
        if (b == HdrByte) begin
          sync_ph = PhFrame;
          next_pos = FirstPayloadPos;
          payload_sum = '0;
        end else begin
          sync_ph = PhHunt;
          next_pos = 0;
        end
      end
      default: begin
        if (b == HdrByte) begin
          sync_ph = PhOne;
          next_pos = HdrPos1;
        end else begin
          sync_ph = PhHunt;
          next_pos = 0;
        end
        payload_sum = '0;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i <= '0;
      tx_gap <= 0;
    end else if (!rx_valid_i || rx_ready_o) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        rx_valid_i <= 1'b0;
      end else if (rx_stream.size() != 0) begin
        rx_valid_i <= 1'b1;
        rx_byte_i <= rx_stream.pop_front();
        tx_gap <= draw_gap(((cycle_count / 300) % 4) == 1);
      end else begin
        rx_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else begin
      rx_stall <= draw_gap(((cycle_count / 300) % 4) == 3);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) begin
        predict_rx(rx_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        got = '{data_byte_o, position_o, frame_end_o, frame_ok_o};
        if (frame_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected item data=%h pos=%0d end=%b ok=%b", $realtime,
                     got.data_byte, got.position, got.frame_end, got.frame_ok);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = frame_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch data=%h/%h pos=%0d/%0d end=%b/%b ok=%b/%b (exp/act)",
                       $realtime, want.data_byte, got.data_byte, want.position,
                       got.position, want.frame_end, got.frame_end, want.frame_ok,
                       got.frame_ok);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned n;

    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'h7F);
    rx_stream.push_back(8'h80);
    rx_stream.push_back(8'hFE);
    rx_stream.push_back(HdrByte);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(HdrByte);
    rx_stream.push_back(8'hFE);
    add_frame(1'b1, 1);
    add_frame(1'b1, 3);
    add_frame(1'b0, 0);
    add_frame(1'b1, 2);

    while (rx_stream.size() < RandomBytes) begin
      r = $urandom_range(99);
      if (r < 70) begin
        n = $urandom_range(3);
        repeat (n) rx_stream.push_back(8'($urandom_range(254)));
        add_frame(1'b1, 0);
      end else if (r < 80) begin
        add_frame(1'b0, 0);
      end else if (r < 88) begin
        add_frame($urandom_range(1), 2);
      end else if (r < 94) begin
        rx_stream.push_back(HdrByte);
        rx_stream.push_back(8'($urandom_range(254)));
      end else begin
        n = $urandom_range(8, 1);
        repeat (n) rx_stream.push_back(8'($urandom_range(255)));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_stream.size() != 0 || rx_valid_i) @(posedge clk_i);
    while (frame_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && frame_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== fixed_frame_sync_checksum_rx.f =====
rtl/ffsc_pkg.sv
rtl/ffsc_tracker.sv
rtl/ffsc_out_reg.sv
rtl/fixed_frame_sync_checksum_rx.sv
sim/testbench.sv
